[sv/rmfl_pkg.sv]
// Shared types and constants for the region map floor lookup block.
// Used by rmfl_ctrl and region_map_floor_lookup; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rmfl_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    STAT_STORED      = 3'd0,
    STAT_REMOVED     = 3'd1,
    STAT_REMOVE_MISS = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_HIT         = 3'd4,
    STAT_MISS        = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_QRES
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] address;
    logic [63:0] size;
    logic        is_pointer;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] remaining_size;
  } out_item_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
  } region_t;

endpackage

`default_nettype wire

[sv/rmfl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the sorted region table.
`timescale 1ns / 1ps
`default_nettype none

module rmfl_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[sv/rmfl_ctrl.sv]
// Sequencer that walks the sorted region table once per item, shifting entries
// and tracking the floor entry. Depends on rmfl_pkg and rmfl_ram.
`timescale 1ns / 1ps
`default_nettype none

module rmfl_ctrl #(
  parameter int ENTRIES = rmfl_pkg::ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rmfl_pkg::in_item_t  in_data,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output rmfl_pkg::out_item_t      res_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = $bits(rmfl_pkg::region_t);

  rmfl_pkg::state_t    state_r, state_nxt;
  rmfl_pkg::in_item_t  item_r, item_nxt;
  rmfl_pkg::region_t   pend_r, pend_nxt;
  rmfl_pkg::region_t   flr_r, flr_nxt;
  rmfl_pkg::region_t   ent_w;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       proc_idx_r, proc_idx_nxt;
  logic                dv_r, dv_nxt;
  logic                exact_r, exact_nxt;
  logic                placed_r, placed_nxt;
  logic                full_r, full_nxt;
  logic                have_r, have_nxt;
  logic [63:0]         end_r, end_nxt;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [RW-1:0]       ram_rdata;

  logic                is_remove;
  logic                ent_gt;
  logic                ent_eq;

  rmfl_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_w     = rmfl_pkg::region_t'(ram_rdata);
  assign ent_gt    = ent_w.start > item_r.address;
  assign ent_eq    = ent_w.start == item_r.address;
  assign is_remove = (item_r.mode == rmfl_pkg::MODE_RECORD) && (item_r.size == 64'd0);
  assign in_ready  = (state_r == rmfl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmfl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      dv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      dv_r  <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pend_r     <= pend_nxt;
    flr_r      <= flr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    proc_idx_r <= proc_idx_nxt;
    exact_r    <= exact_nxt;
    placed_r   <= placed_nxt;
    full_r     <= full_nxt;
    have_r     <= have_nxt;
    end_r      <= end_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    pend_nxt     = pend_r;
    flr_nxt      = flr_r;
    rd_idx_nxt   = rd_idx_r;
    cnt_nxt      = cnt_r;
    proc_idx_nxt = proc_idx_r;
    dv_nxt       = dv_r;
    exact_nxt    = exact_r;
    placed_nxt   = placed_r;
    full_nxt     = full_r;
    have_nxt     = have_r;
    end_nxt      = end_r;
    ram_we       = 1'b0;
    ram_waddr    = proc_idx_r;
    ram_wdata    = pend_r;
    ram_raddr    = rd_idx_r[IW-1:0];
    res_valid    = 1'b0;
    res_data     = '{status: rmfl_pkg::STAT_MISS, remaining_size: 64'd0};

    unique case (state_r)
      rmfl_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          pend_nxt   = '{start: in_data.address, size: in_data.size};
          rd_idx_nxt = '0;
          dv_nxt     = 1'b0;
          exact_nxt  = 1'b0;
          placed_nxt = 1'b0;
          have_nxt   = 1'b0;
          full_nxt   = (cnt_r == CW'(ENTRIES));
          state_nxt  = rmfl_pkg::ST_SCAN;
        end
      end

      rmfl_pkg::ST_SCAN: begin
        if (rd_idx_r < cnt_r) begin
          rd_idx_nxt   = rd_idx_r + CW'(1);
          proc_idx_nxt = rd_idx_r[IW-1:0];
          dv_nxt       = 1'b1;
        end else begin
          dv_nxt = 1'b0;
          if (!dv_r) begin
            state_nxt = rmfl_pkg::ST_TAIL;
          end
        end
        if (dv_r) begin
          if (item_r.mode == rmfl_pkg::MODE_QUERY) begin
            if (!ent_gt) begin
              flr_nxt  = ent_w;
              have_nxt = 1'b1;
            end
          end else if (is_remove) begin
            if (exact_r) begin
              ram_we    = 1'b1;
              ram_waddr = proc_idx_r - IW'(1);
              ram_wdata = RW'(ent_w);
            end else if (ent_eq) begin
              exact_nxt = 1'b1;
            end
          end else begin
            if (!placed_r && ent_eq) begin
              ram_we    = 1'b1;
              ram_wdata = {item_r.address, item_r.size};
              exact_nxt = 1'b1;
            end else if (!exact_r && !full_r && (placed_r || ent_gt)) begin
              ram_we     = 1'b1;
              ram_wdata  = RW'(pend_r);
              pend_nxt   = ent_w;
              placed_nxt = 1'b1;
            end
          end
        end
      end

      rmfl_pkg::ST_TAIL: begin
        if (item_r.mode == rmfl_pkg::MODE_QUERY) begin
          end_nxt   = flr_r.start + flr_r.size;
          state_nxt = rmfl_pkg::ST_QRES;
        end else begin
          res_valid = 1'b1;
          if (is_remove) begin
            res_data.status = exact_r ? rmfl_pkg::STAT_REMOVED : rmfl_pkg::STAT_REMOVE_MISS;
          end else if (exact_r) begin
            res_data.status = rmfl_pkg::STAT_STORED;
          end else if (full_r) begin
            res_data.status = rmfl_pkg::STAT_FULL;
          end else begin
            res_data.status = rmfl_pkg::STAT_STORED;
          end
          if (res_ready) begin
            state_nxt = rmfl_pkg::ST_IDLE;
            if (is_remove) begin
              if (exact_r) begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end else if (!exact_r && !full_r) begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[IW-1:0];
              ram_wdata = RW'(pend_r);
              cnt_nxt   = cnt_r + CW'(1);
            end
          end
        end
      end

      rmfl_pkg::ST_QRES: begin
        res_valid = 1'b1;
        if (item_r.is_pointer && have_r && (item_r.address < end_r)) begin
          res_data.status         = rmfl_pkg::STAT_HIT;
          res_data.remaining_size = end_r - item_r.address;
        end
        if (res_ready) begin
          state_nxt = rmfl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rmfl_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ENTRIES))
    else $error("entry count exceeds table depth");

  a_cnt_only_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rmfl_pkg::ST_TAIL) |=> $stable(cnt_r))
    else $error("entry count changed outside the tail step");

  a_dv_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == rmfl_pkg::ST_SCAN))
    else $error("read data flagged outside the scan");

  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !exact_r && (state_r == rmfl_pkg::ST_TAIL)) |-> !ram_we)
    else $error("write into a full table");

  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ((state_r == rmfl_pkg::ST_TAIL) || (state_r == rmfl_pkg::ST_QRES)))
    else $error("result raised outside a result step");
`endif

endmodule

`default_nettype wire

[sv/region_map_floor_lookup.sv]
// Top level of the region map floor lookup: table sequencer plus output register.
// Depends on rmfl_pkg and rmfl_ctrl.
//
//   channel  ports                       direction  payload
//   input    in_valid in_stall in_data    in         mode, address, size, is_pointer
//   output   out_valid out_stall out_data out        status, remaining_size
//
// Each item makes one pass over the table through the single RAM read port;
// a query then passes through ST_TAIL and ST_QRES, a record answers in ST_TAIL.
// Reset clears the entry count; table contents need no clearing.
// in_stall is high while an item is in work; a held result stalls only the final step.
`timescale 1ns / 1ps
`default_nettype none

module region_map_floor_lookup #(
  parameter int ENTRIES = rmfl_pkg::ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rmfl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rmfl_pkg::out_item_t      out_data
);

  logic                in_ready;
  logic                res_valid;
  logic                res_ready;
  rmfl_pkg::out_item_t res_data;
  logic                out_valid_r;
  rmfl_pkg::out_item_t out_data_r;

  rmfl_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign in_stall  = !in_ready;
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire
